FILE: rtl/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

    localparam int SECTOR_W = 48;
    localparam int LEN_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int OFF_W    = 12;
    localparam int CLEN_W   = 13;
    localparam int SHIFT_W  = 4;
    localparam int CFG_W    = 16;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd9;
    localparam logic [COUNT_W-1:0] RUN_RESET   = 16'd128;

    localparam int DEF_MAX_SPAN = 64;

    // configuration register indexes
    localparam logic REG_SECTOR_SHIFT = 1'b0;
    localparam logic REG_MAX_RUN      = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture a new request
        logic emit_err;  // emit the span error result
        logic step;      // emit one command and advance
    } srs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic zero_len;
        logic too_long;
        logic step_last;
    } srs_sts_t;

endpackage

FILE: rtl/srs_ctrl.sv
`timescale 1ns / 1ps

module srs_ctrl
    import srs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  srs_sts_t sts,
    output srs_cmd_t cmd,
    output logic     busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.emit_err = 1'b0;
        cmd.step     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.zero_len)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.too_long)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/srs_dp.sv
`timescale 1ns / 1ps

module srs_dp
    import srs_pkg::*;
#(
    parameter int MAX_SPAN = DEF_MAX_SPAN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [SECTOR_W-1:0] start_byte,
    input  logic [LEN_W-1:0]    length_bytes,
    input  srs_cmd_t            cmd,
    output srs_sts_t            sts,
    output logic                strobe,
    output logic [SECTOR_W-1:0] cmd_sector,
    output logic [COUNT_W-1:0]  cmd_count,
    output logic                via_bounce,
    output logic [OFF_W-1:0]    copy_offset,
    output logic [CLEN_W-1:0]   copy_length,
    output logic                too_long,
    output logic                last
);

    // config
    logic [SHIFT_W-1:0]  shift_reg;
    logic [COUNT_W-1:0]  run_reg;

    // walk state
    logic [SECTOR_W-1:0] sector_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [LEN_W-1:0]    rem_reg;

    // result registers
    logic                strobe_reg;
    logic [SECTOR_W-1:0] sector_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic                bounce_out_reg;
    logic [OFF_W-1:0]    off_out_reg;
    logic [CLEN_W-1:0]   clen_out_reg;
    logic                err_out_reg;
    logic                last_out_reg;

    logic [SHIFT_W-1:0]  sh_eff;
    logic [COUNT_W-1:0]  run_eff;
    logic [CLEN_W-1:0]   ss;
    logic [OFF_W-1:0]    off_mask;
    logic [LEN_W:0]      span_sum;
    logic [LEN_W:0]      span_m1;
    logic [CLEN_W-1:0]   room;
    logic                partial;
    logic [CLEN_W-1:0]   piece;
    logic [LEN_W-1:0]    nfull;
    logic [COUNT_W-1:0]  run_cnt;
    logic [LEN_W-1:0]    run_bytes;
    logic [LEN_W-1:0]    rem_next;
    logic [SECTOR_W-1:0] sector_next;
    logic [COUNT_W-1:0]  step_cnt;

    always_comb
    begin
        if (shift_reg < SHIFT_MIN)
        begin
            sh_eff = SHIFT_MIN;
        end
        else if (shift_reg > SHIFT_MAX)
        begin
            sh_eff = SHIFT_MAX;
        end
        else
        begin
            sh_eff = shift_reg;
        end
    end

    assign run_eff  = (run_reg == '0) ? COUNT_W'(1) : run_reg;
    assign ss       = CLEN_W'(1) << sh_eff;
    assign off_mask = OFF_W'(ss - CLEN_W'(1));

    // sectors touched minus one, from offset in first sector and length
    assign span_sum = {1'b0, rem_reg} + (LEN_W+1)'(off_reg) - (LEN_W+1)'(1);
    assign span_m1  = span_sum >> sh_eff;

    assign room    = ss - CLEN_W'(off_reg);
    assign partial = (off_reg != '0) || (rem_reg < LEN_W'(ss));
    assign piece   = (rem_reg < LEN_W'(room)) ? CLEN_W'(rem_reg) : room;

    assign nfull     = rem_reg >> sh_eff;
    assign run_cnt   = (nfull > LEN_W'(run_eff)) ? run_eff : COUNT_W'(nfull);
    assign run_bytes = LEN_W'(run_cnt) << sh_eff;

    assign step_cnt    = partial ? COUNT_W'(1) : run_cnt;
    assign rem_next    = rem_reg - (partial ? LEN_W'(piece) : run_bytes);
    assign sector_next = sector_reg + SECTOR_W'(step_cnt);

    assign sts.zero_len  = (rem_reg == '0);
    assign sts.too_long  = (span_m1 >= (LEN_W+1)'(MAX_SPAN));
    assign sts.step_last = (rem_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= SHIFT_RESET;
            run_reg    <= RUN_RESET;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SECTOR_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                    REG_MAX_RUN:      run_reg   <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
            strobe_reg <= cmd.step | cmd.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sector_reg <= start_byte >> sh_eff;
            off_reg    <= start_byte[OFF_W-1:0] & off_mask;
            rem_reg    <= length_bytes;
        end
        else if (cmd.step)
        begin
            sector_reg <= sector_next;
            off_reg    <= '0;
            rem_reg    <= rem_next;
        end

        if (cmd.emit_err)
        begin
            sector_out_reg <= sector_reg;
            count_out_reg  <= '0;
            bounce_out_reg <= 1'b0;
            off_out_reg    <= '0;
            clen_out_reg   <= '0;
            err_out_reg    <= 1'b1;
            last_out_reg   <= 1'b1;
        end
        else if (cmd.step)
        begin
            sector_out_reg <= sector_reg;
            count_out_reg  <= step_cnt;
            bounce_out_reg <= partial;
            off_out_reg    <= partial ? off_reg : '0;
            clen_out_reg   <= partial ? piece : '0;
            err_out_reg    <= 1'b0;
            last_out_reg   <= sts.step_last;
        end
    end

    assign strobe      = strobe_reg;
    assign cmd_sector  = sector_out_reg;
    assign cmd_count   = count_out_reg;
    assign via_bounce  = bounce_out_reg;
    assign copy_offset = off_out_reg;
    assign copy_length = clen_out_reg;
    assign too_long    = err_out_reg;
    assign last        = last_out_reg;

endmodule

FILE: rtl/sector_read_splitter_core.sv
`timescale 1ns / 1ps

// Sector read splitter.
// Turns a byte-range read (start_byte, length_bytes) into sector commands in
// address order: a partly covered sector becomes a one-sector bounce read with
// copy_offset/copy_length, and runs of whole sectors merge into commands of up
// to max_run sectors.
// Request channel: a beat is taken on a rising edge with start high and busy
// low. Config channel: cfg_valid/cfg_ready with cfg_index (0 = sector_shift,
// 1 = max_run) and cfg_data; cfg_ready is always high. Write config only
// while busy is low and no result is still due.
// Results: each beat sits on the result ports for one cycle, flagged by
// strobe, and is taken at the end of that cycle; the receiver cannot stall.
// The first result follows the range check (ST_CHECK) and a command step
// (ST_RUN) via the registered strobe. Busy stays high over the check and
// the command steps, one command per cycle from the run walker. A zero
// length gives no results; busy drops after the range check. An over-span
// request gives one error beat from the check, sooner than a first command.
// The next request may be accepted while the final beat is showing.
// Reset: async, active low; returns to idle, sector_shift = 9, max_run = 128.

module sector_read_splitter_core
    import srs_pkg::*;
#(
    parameter int MAX_SPAN = DEF_MAX_SPAN
)
(
    input  logic                clk,
    input  logic                rst_n,
    // request
    input  logic                start,
    output logic                busy,
    input  logic [SECTOR_W-1:0] start_byte,
    input  logic [LEN_W-1:0]    length_bytes,
    // config write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // results
    output logic                strobe,
    output logic [SECTOR_W-1:0] cmd_sector,
    output logic [COUNT_W-1:0]  cmd_count,
    output logic                via_bounce,
    output logic [OFF_W-1:0]    copy_offset,
    output logic [CLEN_W-1:0]   copy_length,
    output logic                too_long,
    output logic                last
);

    srs_cmd_t cmd;
    srs_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencing: idle -> range check -> one command per cycle
    srs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // config registers, sector walker and result registers
    srs_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_byte   (start_byte),
        .length_bytes (length_bytes),
        .cmd          (cmd),
        .sts          (sts),
        .strobe       (strobe),
        .cmd_sector   (cmd_sector),
        .cmd_count    (cmd_count),
        .via_bounce   (via_bounce),
        .copy_offset  (copy_offset),
        .copy_length  (copy_length),
        .too_long     (too_long),
        .last         (last)
    );

`ifndef SYNTH
    // error beat is always the only and final beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && too_long |-> last && !via_bounce && cmd_count == '0)
        else $error("error beat malformed");

    // bounce reads cover one sector and copy something
    a_bounce: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && via_bounce |-> cmd_count == COUNT_W'(1) && copy_length != '0)
        else $error("bounce beat malformed");

    // a merged command moves at least one sector
    a_merge: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !via_bounce && !too_long |-> cmd_count != '0)
        else $error("empty merged command");

    // an accepted request always occupies the block next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request dropped");
`endif

endmodule

FILE: sim/srs_checker.sv
`timescale 1ns / 1ps

module srs_checker
    import srs_pkg::*;
#(
    parameter int MAX_SPAN = DEF_MAX_SPAN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [SECTOR_W-1:0] start_byte,
    input  logic [LEN_W-1:0]    length_bytes,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                strobe,
    input  logic [SECTOR_W-1:0] cmd_sector,
    input  logic [COUNT_W-1:0]  cmd_count,
    input  logic                via_bounce,
    input  logic [OFF_W-1:0]    copy_offset,
    input  logic [CLEN_W-1:0]   copy_length,
    input  logic                too_long,
    input  logic                last,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
        logic                bounce;
        logic [OFF_W-1:0]    offset;
        logic [CLEN_W-1:0]   clen;
        logic                err;
        logic                last;
    } sector_cmd_t;

    sector_cmd_t          cmd_due[$];
    logic [SHIFT_W-1:0]   shift_reg;
    logic [COUNT_W-1:0]   run_reg;

    task automatic push_cmd(input logic [63:0] sec, input logic [63:0] cnt, input logic bounce,
                            input logic [63:0] off, input logic [63:0] clen, input logic err);
        sector_cmd_t c;
        c.sector = sec[SECTOR_W-1:0];
        c.count  = cnt[COUNT_W-1:0];
        c.bounce = bounce;
        c.offset = off[OFF_W-1:0];
        c.clen   = clen[CLEN_W-1:0];
        c.err    = err;
        c.last   = 1'b0;
        cmd_due.push_back(c);
    endtask

    // sector commands for one read, appended to cmd_due
    task automatic split_request(input logic [SECTOR_W-1:0] sb, input logic [LEN_W-1:0] lb);
        int          sh;
        logic [63:0] sec_size;
        logic [63:0] run_lim;
        logic [63:0] pos;
        logic [63:0] remain;
        logic [63:0] first_sec;
        logic [63:0] last_sec;
        logic [63:0] off;
        logic [63:0] piece;
        logic [63:0] merge_first;
        logic [63:0] merge_cnt;
        bit          merging;
        if (lb == '0)
            return;
        sh = int'(shift_reg);
        if (sh < 9)
            sh = 9;
        if (sh > 12)
            sh = 12;
        sec_size    = 64'd1 << sh;
        run_lim     = (run_reg == '0) ? 64'd1 : {48'd0, run_reg};
        pos         = {16'd0, sb};
        remain      = {32'd0, lb};
        first_sec   = pos >> sh;
        last_sec    = (pos + remain - 64'd1) >> sh;
        merging     = 1'b0;
        merge_first = '0;
        merge_cnt   = '0;
        if (last_sec - first_sec + 64'd1 > 64'(MAX_SPAN))
        begin
            push_cmd(first_sec, 64'd0, 1'b0, 64'd0, 64'd0, 1'b1);
            cmd_due[cmd_due.size()-1].last = 1'b1;
            return;
        end
        while (remain != 64'd0)
        begin
            off   = pos & (sec_size - 64'd1);
            piece = sec_size - off;
            if (piece > remain)
                piece = remain;
            if (merging && merge_cnt == run_lim)
            begin
                push_cmd(merge_first, merge_cnt, 1'b0, 64'd0, 64'd0, 1'b0);
                merging = 1'b0;
            end
            if (off != 64'd0 || piece != sec_size)
            begin
                // partial sector: flush the run, then a bounce read
                if (merging)
                begin
                    push_cmd(merge_first, merge_cnt, 1'b0, 64'd0, 64'd0, 1'b0);
                    merging = 1'b0;
                end
                push_cmd(pos >> sh, 64'd1, 1'b1, off, piece, 1'b0);
            end
            else
            begin
                if (!merging)
                begin
                    merging     = 1'b1;
                    merge_first = pos >> sh;
                    merge_cnt   = 64'd0;
                end
                merge_cnt++;
            end
            pos    += piece;
            remain -= piece;
        end
        if (merging)
            push_cmd(merge_first, merge_cnt, 1'b0, 64'd0, 64'd0, 1'b0);
        cmd_due[cmd_due.size()-1].last = 1'b1;
    endtask

    function automatic int field_diff(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
        if (exp_v === act_v)
            return 0;
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sector_cmd_t e;
        if (!rst_n)
        begin
            shift_reg = SHIFT_RESET;
            run_reg   = RUN_RESET;
            cmd_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // result beat: check against the oldest command due
            if (strobe)
            begin
                if (cmd_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none actual sector %0h count %0h",
                             $time, cmd_sector, cmd_count);
                    fail_count++;
                end
                else
                begin
                    e = cmd_due.pop_front();
                    fail_count += field_diff("cmd_sector", 64'(e.sector), 64'(cmd_sector));
                    fail_count += field_diff("cmd_count", 64'(e.count), 64'(cmd_count));
                    fail_count += field_diff("via_bounce", 64'(e.bounce), 64'(via_bounce));
                    fail_count += field_diff("copy_offset", 64'(e.offset), 64'(copy_offset));
                    fail_count += field_diff("copy_length", 64'(e.clen), 64'(copy_length));
                    fail_count += field_diff("too_long", 64'(e.err), 64'(too_long));
                    fail_count += field_diff("last", 64'(e.last), 64'(last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SECTOR_SHIFT)
                    shift_reg = cfg_data[SHIFT_W-1:0];
                else
                    run_reg = cfg_data[COUNT_W-1:0];
            end
            if (start && !busy)
                split_request(start_byte, length_bytes);
            pending = cmd_due.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srs_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 7;
    // leave plenty of room over the slowest correct run
    localparam int RUN_LIMIT = 300000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [SECTOR_W-1:0] start_byte;
    logic [LEN_W-1:0]    length_bytes;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                strobe;
    logic [SECTOR_W-1:0] cmd_sector;
    logic [COUNT_W-1:0]  cmd_count;
    logic                via_bounce;
    logic [OFF_W-1:0]    copy_offset;
    logic [CLEN_W-1:0]   copy_length;
    logic                too_long;
    logic                last;

    int fail_count;
    int pending;
    int cycle_count;
    // effective sector shift as last written, used only to shape stimulus
    int eff_shift;

    sector_read_splitter_core #(
        .MAX_SPAN (DEF_MAX_SPAN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_byte   (start_byte),
        .length_bytes (length_bytes),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .cmd_sector   (cmd_sector),
        .cmd_count    (cmd_count),
        .via_bounce   (via_bounce),
        .copy_offset  (copy_offset),
        .copy_length  (copy_length),
        .too_long     (too_long),
        .last         (last)
    );

    srs_checker #(
        .MAX_SPAN (DEF_MAX_SPAN)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_byte   (start_byte),
        .length_bytes (length_bytes),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .cmd_sector   (cmd_sector),
        .cmd_count    (cmd_count),
        .via_bounce   (via_bounce),
        .copy_offset  (copy_offset),
        .copy_length  (copy_length),
        .too_long     (too_long),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // watchdog: a hung handshake or a lost beat ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One request beat. start stays high until the edge that takes it; the
    // gap afterwards (if any) drops start so idle cycles land at random
    // points of the block's command walk.
    task automatic send_read(input logic [SECTOR_W-1:0] sb, input logic [LEN_W-1:0] lb,
                             input bit may_idle);
        int gap;
        start        <= 1'b1;
        start_byte   <= sb;
        length_bytes <= lb;
        do
            @(posedge clk);
        while (busy);
        gap = 0;
        if (may_idle && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, 12);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every due beat. A zero-length read keeps
    // the block busy with no beat, so also wait out busy and a few cycles.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // Both registers back to back; valid stays high across the two beats.
    task automatic set_config(input logic [CFG_W-1:0] shift_val,
                              input logic [CFG_W-1:0] run_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SECTOR_SHIFT;
        cfg_data  <= shift_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_MAX_RUN;
        cfg_data  <= run_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        eff_shift = int'(shift_val[SHIFT_W-1:0]);
        if (eff_shift < 9)
            eff_shift = 9;
        if (eff_shift > 12)
            eff_shift = 12;
    endtask

    // Random reads shaped for the current sector size. Most are spans that
    // fit MAX_SPAN, mixing aligned runs and ragged ends; the rest are zero
    // length, over-span and fully random lengths.
    task automatic run_phase(input int n_items, input bit quiet, input bit hold_mid);
        logic [15:0]         hi;
        logic [31:0]         lo;
        logic [SECTOR_W-1:0] sb;
        logic [SECTOR_W-1:0] mask;
        logic [LEN_W-1:0]    lb;
        logic [LEN_W-1:0]    ss;
        int                  kind;
        int                  nsec;
        int                  adj;
        ss   = 32'd1 << eff_shift;
        mask = (48'd1 << eff_shift) - 48'd1;
        for (int i = 0; i < n_items; i++)
        begin
            hi = 16'($urandom);
            lo = $urandom;
            sb = {hi, lo};
            if ($urandom_range(0, 3) == 0)
                sb[SECTOR_W-1:32] = '1;
            if ($urandom_range(0, 1) == 1)
                sb = sb & ~mask;
            kind = $urandom_range(0, 99);
            if (kind < 8)
                lb = '0;
            else if (kind < 18)
                lb = $urandom;
            else if (kind < 24)
                lb = ss * 32'($urandom_range(65, 200));
            else
            begin
                if (kind < 70)
                    nsec = $urandom_range(1, 4);
                else if (kind < 90)
                    nsec = $urandom_range(5, 20);
                else
                    nsec = $urandom_range(21, DEF_MAX_SPAN);
                lb  = ss * 32'(nsec);
                adj = $urandom_range(0, 3);
                if (adj == 1)
                    lb = lb - 32'($urandom_range(1, ss - 1));
                else if (adj == 2)
                    lb = 32'($urandom_range(1, ss));
                else if (adj == 3)
                    lb = lb + 32'($urandom_range(1, ss - 1));
            end
            // hold-off: let the block run dry in the middle of a phase
            if (hold_mid && i == n_items / 2)
                drain();
            send_read(sb, lb, !quiet);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] rnd_a;
        logic [CFG_W-1:0] rnd_b;
        rst_n        = 1'b0;
        start        = 1'b0;
        start_byte   = '0;
        length_bytes = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_SECTOR_SHIFT;
        cfg_data     = '0;
        eff_shift    = 9;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset config (512-byte sectors, runs of 128)
        send_read(48'h0, 32'd0, 1'b0);                    // zero length
        send_read(48'h0, 32'd1, 1'b0);                    // one byte at sector start
        send_read(48'h1FF, 32'd1, 1'b0);                  // last byte of a sector
        send_read(48'h200, 32'd512, 1'b0);                // one whole sector
        send_read(48'h100, 32'd1024, 1'b0);               // head, whole, tail
        send_read(48'h0, 32'd64 * 512, 1'b0);             // widest legal span, one run
        send_read(48'h0, 32'd65 * 512, 1'b0);             // one sector over the span
        send_read(48'h1, 32'd64 * 512, 1'b0);             // misaligned start pushes over
        send_read(48'hFFFF_FFFF_FFFF, 32'd1, 1'b0);       // top byte of the address space
        send_read(48'hFFFF_FFFF_FFFF, 32'd2, 1'b0);       // runs past the top
        send_read(48'hFFFF_FFFF_FE00, 32'd512, 1'b0);     // top sector, whole
        send_read(48'h1234_5678_9A00, 32'hFFFF_FFFF, 1'b0); // longest length
        send_read(48'h5555_5555_5400, 32'd3 * 512 + 7, 1'b0);
        send_read(48'hAAAA_AAAA_AAAA, 32'h8000_0000, 1'b0);
        drain();

        // run limit 0 acts as 1: every whole sector is its own command
        set_config(16'd0, 16'd0);
        send_read(48'h0, 32'd64 * 512, 1'b0);
        send_read(48'h10, 32'd4 * 512, 1'b0);
        drain();

        // shift 15 clamps to 12; runs of 3 split long aligned spans
        set_config(16'hFFFF, 16'd3);
        send_read(48'h0, 32'd10 * 4096, 1'b0);
        send_read(48'h800, 32'd7 * 4096 + 5, 1'b0);
        send_read(48'h0, 32'd64 * 4096, 1'b0);
        send_read(48'h1, 32'd64 * 4096, 1'b0);
        drain();

        // random phases across register settings, extremes included
        set_config(16'd9, 16'd128);
        run_phase(50, 1'b0, 1'b0);
        drain();
        set_config(16'd12, 16'hFFFF);
        run_phase(50, 1'b0, 1'b1);
        drain();
        set_config(16'd5, 16'd1);
        run_phase(50, 1'b0, 1'b0);
        drain();
        // back-to-back stretch: no sender gaps at all
        set_config(16'd10, 16'd2);
        run_phase(50, 1'b1, 1'b0);
        drain();
        set_config(16'd11, 16'd0);
        run_phase(50, 1'b0, 1'b0);
        drain();
        rnd_a = CFG_W'($urandom);
        rnd_b = CFG_W'($urandom);
        set_config({rnd_a[CFG_W-1:SHIFT_W], 4'd13}, rnd_b);
        run_phase(50, 1'b0, 1'b1);
        drain();
        rnd_a = CFG_W'($urandom);
        rnd_b = CFG_W'($urandom);
        set_config(rnd_a, rnd_b);
        run_phase(50, 1'b0, 1'b0);

        // everything sent; let stragglers or extra beats show up
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
